// ===== sv/pfa_pkg.sv =====
// pfa_pkg: shared types and constants for the partition fit allocator
// holds policy codes, register indexes, field widths, fsm states and the token control struct
// no dependencies
package pfa_pkg;

    // default configuration of the partition row
    localparam int PARTS_DEF     = 16;
    localparam int SIZE_BITS_DEF = 16;

    // fixed field widths of the ports
    localparam int SLOT_W     = 4;
    localparam int AMT_W      = 16;
    localparam int POLICY_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int CFG_DATA_W = 5;

    // placement policy codes
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    // configuration register indexes
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    // request item mode
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMMIT
    } state_t;

    // control part of the search token that walks the cell row
    typedef struct packed {
        logic valid;
        logic found;
    } tok_ctl_t;

endpackage

// ===== sv/pfa_cell.sv =====
// pfa_cell: one partition slot of the allocator row
// holds the free space of its slot and forwards the search token to its neighbor
// depends on pfa_pkg
module pfa_cell
    import pfa_pkg::*;
#(
    parameter int CELL_IDX  = 0,
    parameter int IDX_W     = 4,
    parameter int SIZE_BITS = SIZE_BITS_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    // load broadcast
    input  logic                 load_en,
    input  logic [SLOT_W-1:0]    load_slot,
    input  logic [SIZE_BITS-1:0] load_val,
    // search context
    input  logic [SIZE_BITS-1:0] want,
    input  logic [POLICY_W-1:0]  policy,
    input  logic [COUNT_W-1:0]   count,
    // token from the left neighbor
    input  tok_ctl_t             tok_in,
    input  logic [IDX_W-1:0]     idx_in,
    input  logic [SIZE_BITS-1:0] left_in,
    // token to the right neighbor
    output tok_ctl_t             tok_out,
    output logic [IDX_W-1:0]     idx_out,
    output logic [SIZE_BITS-1:0] left_out,
    // commit broadcast
    input  logic                 commit_en,
    input  logic [IDX_W-1:0]     commit_idx
);

    logic [SIZE_BITS-1:0] free_reg;
    logic [SIZE_BITS-1:0] free_next;
    tok_ctl_t             tok_reg;
    tok_ctl_t             tok_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic [SIZE_BITS-1:0] left_reg;
    logic [SIZE_BITS-1:0] left_next;

    logic                 active;
    logic                 fits;
    logic [SIZE_BITS-1:0] left_here;
    logic                 take;

    assign active    = CELL_IDX < int'(count);
    assign fits      = active && (free_reg >= want);
    assign left_here = free_reg - want;

    // first fit keeps the earliest hit, strict compares keep ties on the lower slot
    always_comb
    begin
        take = 1'b0;
        if (fits)
        begin
            if (!tok_in.found)
                take = 1'b1;
            else if (policy == POL_BEST && left_here < left_in)
                take = 1'b1;
            else if (policy == POL_WORST && left_here > left_in)
                take = 1'b1;
        end
    end

    always_comb
    begin
        tok_next.valid = tok_in.valid;
        tok_next.found = tok_in.found || (tok_in.valid && take);
        idx_next       = (tok_in.valid && take) ? IDX_W'(CELL_IDX) : idx_in;
        left_next      = (tok_in.valid && take) ? left_here : left_in;
    end

    always_comb
    begin
        free_next = free_reg;
        if (load_en && int'(load_slot) == CELL_IDX)
            free_next = load_val;
        else if (commit_en && int'(commit_idx) == CELL_IDX)
            free_next = free_reg - want;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        left_reg <= left_next;
        free_reg <= free_next;
    end

    assign tok_out  = tok_reg;
    assign idx_out  = idx_reg;
    assign left_out = left_reg;

endmodule

// ===== sv/partition_fit_allocator.sv =====
// partition_fit_allocator: top level of the first/best/worst fit partition allocator
// builds a row of pfa_cell slots, the control fsm, configuration registers and output register
// depends on pfa_pkg and pfa_cell
//
// The block keeps the free space of PARTS fixed partitions, one per cell in a row of cells.
// A load transaction (mode 0) writes one slot's size and does not stall the input.
// A request transaction (mode 1) sends a search token down the row, one cell per cycle;
// each cell compares its free space against the request and the token keeps the slot
// that the policy prefers (ties to the lowest slot). When the token leaves the last cell
// the chosen slot is debited and the result goes into the output register. A request
// occupies the block through launch, the ripple of the token through the row, capture of
// the tail token and commit, which waits until the output register is free. The input is
// stalled while a request is in flight; a finished result may wait in the output register
// while the next transaction is taken. Slots are not cleared at reset: load a slot before
// it is searched. Configuration writes are always ready and are meant to happen while the
// block is idle.
module partition_fit_allocator
    import pfa_pkg::*;
#(
    parameter int PARTS     = PARTS_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  mode,
    input  logic [SLOT_W-1:0]     slot,
    input  logic [AMT_W-1:0]      amount,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  granted,
    output logic [SLOT_W-1:0]     chosen_slot,
    output logic [AMT_W-1:0]      leftover,
    // configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (PARTS > 1) ? $clog2(PARTS) : 1;

    // control state
    state_t                state_reg;
    state_t                state_next;
    logic                  start_reg;
    logic                  start_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [POLICY_W-1:0]   policy_reg;
    logic [POLICY_W-1:0]   policy_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;

    // payload
    logic [SIZE_BITS-1:0]  want_reg;
    logic [SIZE_BITS-1:0]  want_next;
    logic                  res_found_reg;
    logic                  res_found_next;
    logic [IDX_W-1:0]      res_idx_reg;
    logic [IDX_W-1:0]      res_idx_next;
    logic [SIZE_BITS-1:0]  res_left_reg;
    logic [SIZE_BITS-1:0]  res_left_next;
    logic                  granted_reg;
    logic                  granted_next;
    logic [SLOT_W-1:0]     chosen_reg;
    logic [SLOT_W-1:0]     chosen_next;
    logic [AMT_W-1:0]      leftover_reg;
    logic [AMT_W-1:0]      leftover_next;

    // handshakes
    logic                  in_xact;
    logic                  out_xact;
    logic                  load_en;
    logic                  commit_en;

    // token chain, entry 0 is the head driven here, entry PARTS is the tail
    tok_ctl_t              tok_chain  [PARTS+1];
    logic [IDX_W-1:0]      idx_chain  [PARTS+1];
    logic [SIZE_BITS-1:0]  left_chain [PARTS+1];

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xact   = in_valid && !in_stall;
    assign out_xact  = out_valid_reg && !out_stall;
    assign load_en   = in_xact && (mode == MODE_LOAD);
    assign cfg_ready = 1'b1;

    // head of the chain: a fresh token with nothing found yet
    assign tok_chain[0].valid = start_reg;
    assign tok_chain[0].found = 1'b0;
    assign idx_chain[0]       = '0;
    assign left_chain[0]      = '0;

    for (genvar gi = 0; gi < PARTS; gi++)
    begin : g_cell
        pfa_cell #(
            .CELL_IDX  (gi),
            .IDX_W     (IDX_W),
            .SIZE_BITS (SIZE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load_en    (load_en),
            .load_slot  (slot),
            .load_val   (SIZE_BITS'(amount)),
            .want       (want_reg),
            .policy     (policy_reg),
            .count      (count_reg),
            .tok_in     (tok_chain[gi]),
            .idx_in     (idx_chain[gi]),
            .left_in    (left_chain[gi]),
            .tok_out    (tok_chain[gi+1]),
            .idx_out    (idx_chain[gi+1]),
            .left_out   (left_chain[gi+1]),
            .commit_en  (commit_en),
            .commit_idx (res_idx_reg)
        );
    end

    // configuration writes
    always_comb
    begin
        policy_next = policy_reg;
        count_next  = count_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_POLICY: policy_next = cfg_data[POLICY_W-1:0];
                REG_COUNT:  count_next  = cfg_data[COUNT_W-1:0];
                default:    ;
            endcase
        end
    end

    // next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg && !out_xact;
        want_next      = want_reg;
        res_found_next = res_found_reg;
        res_idx_next   = res_idx_reg;
        res_left_next  = res_left_reg;
        granted_next   = granted_reg;
        chosen_next    = chosen_reg;
        leftover_next  = leftover_reg;
        commit_en      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xact && mode == MODE_REQUEST)
                begin
                    want_next  = SIZE_BITS'(amount);
                    start_next = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                // token left the last cell
                if (tok_chain[PARTS].valid)
                begin
                    res_found_next = tok_chain[PARTS].found;
                    res_idx_next   = idx_chain[PARTS];
                    res_left_next  = left_chain[PARTS];
                    state_next     = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                // debit the slot and publish once the output register is free
                if (!out_valid_reg || out_xact)
                begin
                    commit_en      = res_found_reg;
                    out_valid_next = 1'b1;
                    granted_next   = res_found_reg;
                    chosen_next    = res_found_reg ? SLOT_W'(res_idx_reg) : '0;
                    leftover_next  = res_found_reg ? AMT_W'(res_left_reg) : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            policy_reg    <= POL_FIRST;
            count_reg     <= COUNT_W'(16);
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            policy_reg    <= policy_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        want_reg      <= want_next;
        res_found_reg <= res_found_next;
        res_idx_reg   <= res_idx_next;
        res_left_reg  <= res_left_next;
        granted_reg   <= granted_next;
        chosen_reg    <= chosen_next;
        leftover_reg  <= leftover_next;
    end

    assign out_valid   = out_valid_reg;
    assign granted     = granted_reg;
    assign chosen_slot = chosen_reg;
    assign leftover    = leftover_reg;

    // a launched token always finds the fsm searching
    a_start_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> state_reg == ST_SEARCH)
        else $error("search token launched outside search");

    // the tail token only shows up while searching
    a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        tok_chain[PARTS].valid |-> state_reg == ST_SEARCH)
        else $error("tail token outside search");

    // a new result only comes from the commit step
    a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_COMMIT))
        else $error("result without commit");

    // the chosen slot lies inside the searched range
    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT && res_found_reg) |-> (int'(res_idx_reg) < int'(count_reg)))
        else $error("chosen slot beyond partition count");

endmodule
